@@ rtl/direct_mapped_writeback_cache_defines.svh @@
// Assertion macros used by the cache top level.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define DMWBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define DMWBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dmwbc_pkg.sv @@
// Types and codes shared by the direct-mapped write-back cache.
`timescale 1ns / 1ps

package dmwbc_pkg;

   localparam int ClusterWidth = 32;
   localparam int LineIndexWidth = 5;

   // Request function codes carried on tuser.
   typedef enum logic [1:0] {
      FUNC_READ       = 2'd0,
      FUNC_WRITE_FULL = 2'd1,
      FUNC_WRITE_PART = 2'd2,
      FUNC_FLUSH      = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_LOOKUP  = 4'b0010,
      ST_FL_SCAN = 4'b0100,
      ST_FL_EMIT = 4'b1000
   } state_type;

   // Result fields, highest bit first, as they sit on rsp_tdata.
   typedef struct packed {
      logic                      fetch;
      logic [ClusterWidth-1:0]   victim_cluster;
      logic                      write_back;
      logic [LineIndexWidth-1:0] line_index;
      logic                      hit;
   } rsp_data_type;

endpackage

@@ rtl/dmwbc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module dmwbc_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // Read data holds until the next read is issued.
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/direct_mapped_writeback_cache.sv @@
// Top level of the direct-mapped write-back cache tag and control block.
`timescale 1ns / 1ps
`include "direct_mapped_writeback_cache_defines.svh"

// Usage:
//  req_* is the request stream: req_tuser carries the function (read, whole
//  write, partial write, flush), req_tdata the cluster number.
//  rsp_* is the result stream: one result per access, and for a flush one
//  result per dirty line in ascending line order; rsp_tlast marks the final
//  result of a request.
//  Order: an access is looked up in the tag RAM the cycle after it is
//  accepted; its result is registered once the output register is free.  A
//  new request is taken only in the idle step, so none is taken until the
//  current one has finished its tag RAM read-modify-write.
//  A flush scans the valid/dirty flops one line per cycle; each dirty line
//  adds an emit step for its tag RAM read, held while the output is busy.
//  Reset clears the valid and dirty flops at once; the tag RAM is not
//  cleared since tags are only read for valid lines.  No clearing pass.
//  Stall: each result sits in an output register.  A request can be taken
//  while it waits; the block then holds in its lookup or flush step until
//  the receiver takes the pending result.
module direct_mapped_writeback_cache
   import dmwbc_pkg::*;
#(
   parameter int LINES = 32,
   parameter int ADDRESS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] cluster
   input  logic [1:0]  req_tuser,   // [1:0] func
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] hit, [5:1] line_index, [6] write_back,
                                    // [38:7] victim_cluster, [39] fetch
   output logic        rsp_tlast
);

   localparam int IDX_W = $clog2(LINES);
   // Only cluster bits below ADDRESS_BITS take part in tag matching.
   localparam int CW = (ADDRESS_BITS < ClusterWidth) ? ADDRESS_BITS : ClusterWidth;

   state_type state_ff, state_in;

   logic [LINES-1:0] valid_ff, valid_in;
   logic [LINES-1:0] dirty_ff, dirty_in;
   logic [LINES-1:0] vd;          // lines that need a write-back
   logic [LINES-1:0] vd_above;    // dirty lines above the flush pointer

   logic [CW-1:0]    cl_ff, cl_in;
   func_type         func_ff, func_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             none_ff, none_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_accept;
   logic             out_free;
   logic             load;

   logic [CW-1:0]    req_cl;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] cur_idx;
   logic [5:0]       cur_idx_wide;
   logic [5:0]       ptr_wide;

   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [CW-1:0]    ram_rd_data;

   logic             hit;
   logic             wb;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_cl  = req_tdata[CW-1:0];
   assign req_idx = req_cl[IDX_W-1:0] & IDX_W'(LINES - 1);
   assign cur_idx = cl_ff[IDX_W-1:0] & IDX_W'(LINES - 1);

   assign cur_idx_wide = 6'(cur_idx);
   assign ptr_wide     = 6'(ptr_ff);

   assign vd = valid_ff & dirty_ff;

   always_comb begin
      for (int i = 0; i < LINES; i++) begin
         vd_above[i] = vd[i] && (i > int'(ptr_ff));
      end
   end

   // Tag lookup against the RAM word read on the accept edge.
   assign hit = valid_ff[cur_idx] && (ram_rd_data == cl_ff);
   assign wb  = !hit && valid_ff[cur_idx] && dirty_ff[cur_idx];

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      dirty_in    = dirty_ff;
      cl_in       = cl_ff;
      func_in     = func_ff;
      ptr_in      = ptr_ff;
      none_in     = none_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      load        = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = req_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cl_in   = req_cl;
               func_in = func_type'(req_tuser);
               ptr_in  = '0;
               none_in = (vd == '0);
               if (func_type'(req_tuser) == FUNC_FLUSH) begin
                  state_in = ST_FL_SCAN;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               load                       = 1'b1;
               rsp_data_in.hit            = hit;
               rsp_data_in.line_index     = cur_idx_wide[LineIndexWidth-1:0];
               rsp_data_in.write_back     = wb;
               rsp_data_in.victim_cluster = wb ? ClusterWidth'(ram_rd_data) : '0;
               rsp_data_in.fetch          = !hit && (func_ff != FUNC_WRITE_FULL);
               rsp_last_in                = 1'b1;
               if (!hit) begin
                  ram_wr_en         = 1'b1;
                  valid_in[cur_idx] = 1'b1;
                  dirty_in[cur_idx] = 1'b0;
               end
               if (func_ff != FUNC_READ) begin
                  dirty_in[cur_idx] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FL_SCAN: begin
            ram_rd_addr = ptr_ff;
            if (none_ff) begin
               // Nothing dirty: a single empty result closes the flush.
               if (out_free) begin
                  load        = 1'b1;
                  rsp_data_in = '0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (vd[ptr_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = ST_FL_EMIT;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         ST_FL_EMIT: begin
            ram_rd_addr = ptr_ff;
            if (out_free) begin
               load                       = 1'b1;
               rsp_data_in.hit            = 1'b0;
               rsp_data_in.line_index     = ptr_wide[LineIndexWidth-1:0];
               rsp_data_in.write_back     = 1'b1;
               rsp_data_in.victim_cluster = ClusterWidth'(ram_rd_data);
               rsp_data_in.fetch          = 1'b0;
               rsp_last_in                = (vd_above == '0);
               valid_in[ptr_ff]           = 1'b0;
               dirty_in[ptr_ff]           = 1'b0;
               if (vd_above == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff + IDX_W'(1);
                  state_in = ST_FL_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cl_ff       <= cl_in;
      func_ff     <= func_in;
      ptr_ff      <= ptr_in;
      none_ff     <= none_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Tag store: holds the full (masked) cluster number of each line.
   dmwbc_ram #(
      .WIDTH (CW),
      .DEPTH (LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cur_idx),
      .wr_data (cl_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A hit never moves data.
   `DMWBC_ASSERT_NOW(a_hit_quiet, rsp_valid_ff && rsp_data_ff.hit,
      !rsp_data_ff.write_back && !rsp_data_ff.fetch, "hit result with write-back or fetch")

   // No victim number without a write-back.
   `DMWBC_ASSERT_NOW(a_victim_zero, rsp_valid_ff && !rsp_data_ff.write_back,
      rsp_data_ff.victim_cluster == '0, "victim cluster set without write-back")

   // The final flush write-back leaves no dirty line behind.
   `DMWBC_ASSERT_NEXT(a_flush_clean, (state_ff == ST_FL_EMIT) && load && rsp_last_in,
      (valid_ff & dirty_ff) == '0, "dirty line left after flush")

   // A looked-up line is valid afterwards.
   `DMWBC_ASSERT_NEXT(a_line_filled, (state_ff == ST_LOOKUP) && load,
      valid_ff[$past(cur_idx)], "accessed line not valid after lookup")

endmodule

@@ test/tb.sv @@
// Testbench for the direct-mapped write-back cache tag and control block.
`timescale 1ns / 1ps

module tb;
   import dmwbc_pkg::*;

   localparam int CacheLines = 1 << LineIndexWidth;
   localparam int AddressBits = ClusterWidth;
   localparam int IdlePercent = 22;
   localparam int HoldCycles = 400;       // long receiver hold-off
   localparam int HoldAfterRequests = 60;
   localparam int QuietFirst = 180;       // requests with no idling on either side
   localparam int QuietLast = 240;
   localparam int WatchdogLimit = 4000;
   localparam int RandomRequests = 226;

   typedef struct packed {
      func_type          func;
      logic [31:0]       cluster;
      logic              drain;   // wait for every outstanding result first
   } cache_request_type;

   typedef struct packed {
      rsp_data_type data;
      logic         last;
   } cache_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] cluster
   logic [1:0]  req_tuser = FUNC_READ;   // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;   // [0] hit, [5:1] line_index, [6] write_back,
                             // [38:7] victim_cluster, [39] fetch
   logic        rsp_tlast;

   cache_request_type pending_requests[$];
   cache_result_type  expected_results[$];

   // shadow of the tag store
   logic        line_valid[CacheLines];
   logic        line_dirty[CacheLines];
   logic [31:0] line_tag[CacheLines];

   int error_count = 0;
   int req_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_cycles = 0;

   wire quiet = req_count >= QuietFirst && req_count < QuietLast;

   direct_mapped_writeback_cache #(
      .LINES(CacheLines),
      .ADDRESS_BITS(AddressBits)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Work out the results of one accepted request and update the shadow tags.
   function automatic void predict_cache_access(input func_type func,
                                                input logic [31:0] cluster);
      cache_result_type r;
      int last_dirty;
      logic [LineIndexWidth-1:0] idx;
      last_dirty = -1;
      if (func == FUNC_FLUSH) begin
         for (int i = 0; i < CacheLines; i++) begin
            if (line_valid[i] && line_dirty[i]) last_dirty = i;
         end
         if (last_dirty < 0) begin
            // nothing dirty: one empty result
            r = '0;
            r.last = 1'b1;
            expected_results.push_back(r);
         end else begin
            for (int i = 0; i < CacheLines; i++) begin
               if (line_valid[i] && line_dirty[i]) begin
                  r = '0;
                  r.data.line_index = LineIndexWidth'(i);
                  r.data.write_back = 1'b1;
                  r.data.victim_cluster = line_tag[i];
                  r.last = (i == last_dirty);
                  expected_results.push_back(r);
                  line_valid[i] = 1'b0;
                  line_dirty[i] = 1'b0;
               end
            end
         end
      end else begin
         idx = cluster[LineIndexWidth-1:0];
         r = '0;
         r.last = 1'b1;
         r.data.line_index = idx;
         r.data.hit = line_valid[idx] && line_tag[idx] == cluster;
         if (!r.data.hit) begin
            if (line_valid[idx] && line_dirty[idx]) begin
               r.data.write_back = 1'b1;
               r.data.victim_cluster = line_tag[idx];
            end
            // whole-cluster writes need no fetch
            r.data.fetch = (func != FUNC_WRITE_FULL);
            line_tag[idx] = cluster;
            line_valid[idx] = 1'b1;
            line_dirty[idx] = 1'b0;
         end
         if (func != FUNC_READ) line_dirty[idx] = 1'b1;
         expected_results.push_back(r);
      end
   endfunction

   function automatic void queue_request(input func_type func, input logic [31:0] cluster,
                                         input logic drain);
      cache_request_type q;
      q.func = func;
      q.cluster = cluster;
      q.drain = drain;
      pending_requests.push_back(q);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   // Request driver: holds tvalid and data steady until the handshake.
   always @(posedge clock) begin : request_driver
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_cache_access(func_type'(req_tuser), req_tdata);
            void'(pending_requests.pop_front());
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            offer = pending_requests.size() > 0
               && (quiet || $urandom_range(0, 99) >= IdlePercent)
               && !(pending_requests[0].drain && expected_results.size() > 0);
            req_tvalid <= offer;
            if (offer) begin
               req_tdata <= pending_requests[0].cluster;
               req_tuser <= pending_requests[0].func;
            end
         end
      end
   end

   // Result monitor: checks each result against the oldest expectation.
   always @(posedge clock) begin : result_monitor
      cache_result_type want;
      rsp_data_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_data_type'(rsp_tdata);
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_results.pop_front();
               check_field("hit", 32'(want.data.hit), 32'(got.hit));
               check_field("line_index", 32'(want.data.line_index), 32'(got.line_index));
               check_field("write_back", 32'(want.data.write_back), 32'(got.write_back));
               check_field("victim_cluster", want.data.victim_cluster, got.victim_cluster);
               check_field("fetch", 32'(want.data.fetch), 32'(got.fetch));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
         // one long hold-off so the block backs up and stalls its input
         if (!hold_done && req_count >= HoldAfterRequests) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || $urandom_range(0, 99) >= IdlePercent;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] tag_pool[4];
      logic [31:0] cluster;
      func_type func;
      int roll;
      int pick;

      for (int i = 0; i < CacheLines; i++) begin
         line_valid[i] = 1'b0;
         line_dirty[i] = 1'b0;
         line_tag[i] = '0;
      end

      // directed: hits, misses, victims, flushes with and without dirty lines
      queue_request(FUNC_READ, 32'h0000_0000, 1'b0);        // cold miss
      queue_request(FUNC_READ, 32'h0000_0000, 1'b0);        // hit
      queue_request(FUNC_WRITE_PART, 32'h0000_0000, 1'b0);  // hit, now dirty
      queue_request(FUNC_READ, 32'h0000_0020, 1'b0);        // dirty victim, read clears dirty
      queue_request(FUNC_WRITE_FULL, 32'hFFFF_FFFF, 1'b0);  // miss with no fetch
      queue_request(FUNC_WRITE_FULL, 32'hFFFF_FFDF, 1'b0);  // victim all ones
      queue_request(FUNC_WRITE_PART, 32'h8000_0001, 1'b0);
      queue_request(FUNC_WRITE_FULL, 32'h8000_0001, 1'b0);
      queue_request(FUNC_READ, 32'h8000_0001, 1'b0);        // read hit keeps dirty
      queue_request(FUNC_FLUSH, 32'h0000_0000, 1'b0);       // two write-backs
      queue_request(FUNC_FLUSH, 32'hFFFF_FFFF, 1'b0);       // nothing dirty
      queue_request(FUNC_READ, 32'h0000_0020, 1'b0);        // clean line survived flush
      queue_request(FUNC_READ, 32'hFFFF_FFDF, 1'b0);        // flushed line is invalid
      queue_request(FUNC_WRITE_PART, 32'hAAAA_AAAA, 1'b0);
      queue_request(FUNC_WRITE_FULL, 32'h5555_5555, 1'b0);
      queue_request(FUNC_READ, 32'h5555_5535, 1'b0);
      queue_request(FUNC_WRITE_FULL, 32'hAAAA_AAAA, 1'b0);
      queue_request(FUNC_WRITE_PART, 32'h0000_0010, 1'b0);
      queue_request(FUNC_FLUSH, 32'h1234_5678, 1'b0);       // cluster ignored
      queue_request(FUNC_WRITE_PART, 32'h7FFF_FFFE, 1'b0);
      queue_request(FUNC_READ, 32'h8000_001E, 1'b0);

      for (int k = 0; k < 4; k++) tag_pool[k] = $urandom() & ~32'h1F;

      for (int s = 0; s < RandomRequests; s++) begin
         if (s == 100) begin
            // dirty every line, then flush: longest result burst
            for (int i = 0; i < CacheLines; i++) begin
               func = ($urandom_range(0, 1) == 0) ? FUNC_WRITE_FULL : FUNC_WRITE_PART;
               queue_request(func, tag_pool[$urandom_range(0, 3)] | i, 1'b0);
            end
            queue_request(FUNC_FLUSH, $urandom(), 1'b0);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 6) func = FUNC_FLUSH;
            else if (roll < 45) func = FUNC_READ;
            else if (roll < 70) func = FUNC_WRITE_FULL;
            else func = FUNC_WRITE_PART;
            pick = $urandom_range(0, 99);
            if (pick < 15) cluster = $urandom();
            else if (pick < 65) cluster = tag_pool[$urandom_range(0, 3)] | $urandom_range(0, 3);
            else cluster = tag_pool[$urandom_range(0, 3)] | $urandom_range(0, CacheLines - 1);
            queue_request(func, cluster, s == 0 || s == 200);
         end
      end

      @(posedge clock);
      while (reset) @(posedge clock);
      while (pending_requests.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      // a flush may walk every line; catch any stray results
      repeat (2 * CacheLines + 16) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dmwbc_pkg.sv
rtl/dmwbc_ram.sv
rtl/direct_mapped_writeback_cache.sv
test/tb.sv
